// File: design/tsmf_pkg.sv
package tsmf_pkg;

    localparam int MAX_OPTIONS_DEF = 6;

    localparam int POS_W  = 9;
    localparam int NEXT_W = 10;
    localparam int LIM_W  = 6;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;
    localparam logic [7:0] KIND_MSS = 8'd2;

    localparam logic [LIM_W-1:0] FIXED_HDR_BYTES = 6'd20;
    localparam logic [3:0]       MIN_HDR_WORDS   = 4'd5;

    typedef enum logic [2:0] {
        PH_KIND     = 3'd0,
        PH_LEN      = 3'd1,
        PH_MSS_SKIP = 3'd2,
        PH_MSS_HI   = 3'd3,
        PH_MSS_LO   = 3'd4
    } phase_t;

    localparam logic [2:0] RSN_NOT_SYN   = 3'd0;
    localparam logic [2:0] RSN_EOL       = 3'd1;
    localparam logic [2:0] RSN_MSS       = 3'd2;
    localparam logic [2:0] RSN_BAD_LEN   = 3'd3;
    localparam logic [2:0] RSN_OPT_LIMIT = 3'd4;
    localparam logic [2:0] RSN_STREAM    = 3'd5;

    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    typedef struct packed {
        logic       verdict;
        logic [2:0] reason;
    } res_t;

endpackage

// File: design/tcp_syn_mss_option_filter_top.sv
// TCP SYN MSS option filter.
// Input channel: one option-area byte per item (the bytes after the fixed
// 20-byte TCP header), with first_byte/last_byte framing. On the first byte
// is_tcp, syn_flag and header_words describe the packet.
// Output channel: at most one item per packet, verdict (0 pass, 1 drop) and
// reason, issued for the byte that settles the packet.
// Configuration: wr_en/wr_data load the minimum accepted MSS value; write it
// only while no packet is in flight.
// The result for a deciding byte is registered at the edge at which that byte
// is accepted: into the result register, or the skid register under out_stall.
// Throughput: one byte per cycle while in_stall is low; all per-byte parsing is
// one pass of logic from the input ports into the result register.
// When out_stall is high the pending result holds and a skid register takes
// one more result; in_stall rises only once that skid register is full.
// Reset clears the parser to wait for a first byte, empties the output
// stages and sets the minimum MSS to zero.
module tcp_syn_mss_option_filter_top #(
    parameter int MAX_OPTIONS = tsmf_pkg::MAX_OPTIONS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [15:0] wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] opt_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       is_tcp,
    input  logic       syn_flag,
    input  logic [3:0] header_words,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       verdict,
    output logic [2:0] reason
);
    import tsmf_pkg::*;

    localparam int ITER_W = (MAX_OPTIONS < 1) ? 1 : $clog2(MAX_OPTIONS + 1);
    localparam logic [ITER_W-1:0] ITER_MAX = ITER_W'(MAX_OPTIONS);

    logic [15:0]       mss_min_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NEXT_W-1:0] nxt_reg, nxt_next;
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        mss_hi_reg, mss_hi_next;
    logic              decided_reg, decided_next;

    logic [POS_W-1:0]  cur_pos;
    logic [NEXT_W-1:0] cur_nxt;
    logic [LIM_W-1:0]  cur_lim;
    logic [ITER_W-1:0] cur_iter;
    phase_t            cur_phase;
    logic [7:0]        cur_mss_hi;

    logic [NEXT_W-1:0] len_sum;
    logic [ITER_W-1:0] iter_inc;
    logic [ITER_W-1:0] iter_inc2;

    logic              in_fire;
    logic              hit;
    res_t              hit_res;

    logic              out_valid_reg;
    res_t              out_reg;
    logic              skid_valid_reg;
    res_t              skid_reg;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign verdict   = out_reg.verdict;
    assign reason    = out_reg.reason;

    // A first byte restarts the parse, so the byte is worked on fresh state.
    always_comb
    begin
        if (first_byte)
        begin
            cur_pos    = '0;
            cur_nxt    = '0;
            cur_iter   = '0;
            cur_phase  = PH_KIND;
            cur_mss_hi = '0;
            cur_lim    = (header_words >= MIN_HDR_WORDS)
                         ? ({header_words, 2'b00} - FIXED_HDR_BYTES) : '0;
        end
        else
        begin
            cur_pos    = pos_reg;
            cur_nxt    = nxt_reg;
            cur_iter   = iter_reg;
            cur_phase  = phase_reg;
            cur_mss_hi = mss_hi_reg;
            cur_lim    = lim_reg;
        end
    end

    assign len_sum   = cur_nxt + NEXT_W'(opt_byte);
    assign iter_inc  = cur_iter + ITER_W'(1);
    assign iter_inc2 = cur_iter + ITER_W'(2);

    always_comb
    begin
        pos_next     = pos_reg;
        nxt_next     = nxt_reg;
        lim_next     = lim_reg;
        iter_next    = iter_reg;
        phase_next   = phase_reg;
        mss_hi_next  = mss_hi_reg;
        decided_next = decided_reg;
        hit          = 1'b0;
        hit_res      = '{verdict: VERDICT_PASS, reason: RSN_NOT_SYN};

        if (in_fire && (first_byte || !decided_reg))
        begin
            pos_next    = cur_pos;
            nxt_next    = cur_nxt;
            lim_next    = cur_lim;
            iter_next   = cur_iter;
            phase_next  = cur_phase;
            mss_hi_next = cur_mss_hi;

            if (first_byte && !(is_tcp && syn_flag))
            begin
                hit = 1'b1;
            end
            else
            begin
                if (cur_pos != POS_MAX)
                    pos_next = cur_pos + POS_W'(1);

                unique case (cur_phase)
                    PH_KIND:
                    begin
                        if (NEXT_W'(cur_pos) == cur_nxt)
                        begin
                            priority if (opt_byte == KIND_NOP)
                            begin
                                nxt_next  = NEXT_W'(cur_pos) + NEXT_W'(1);
                                iter_next = iter_inc;
                                if (iter_inc >= ITER_MAX)
                                begin
                                    hit     = 1'b1;
                                    hit_res = '{VERDICT_PASS, RSN_OPT_LIMIT};
                                end
                            end
                            else if (opt_byte == KIND_EOL)
                            begin
                                hit     = 1'b1;
                                hit_res = '{VERDICT_PASS, RSN_EOL};
                            end
                            else if (opt_byte == KIND_MSS)
                                phase_next = PH_MSS_SKIP;
                            else
                                phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        iter_next  = iter_inc;
                        phase_next = PH_KIND;
                        hit        = 1'b1;
                        if (opt_byte == 8'd0)
                        begin
                            // The same option would repeat until iterations run out.
                            if (cur_nxt > NEXT_W'(cur_lim))
                                hit_res = '{VERDICT_DROP, RSN_BAD_LEN};
                            else
                                hit_res = '{VERDICT_PASS, RSN_OPT_LIMIT};
                        end
                        else
                        begin
                            nxt_next = len_sum;
                            priority if (len_sum > NEXT_W'(cur_lim))
                                hit_res = '{VERDICT_DROP, RSN_BAD_LEN};
                            else if (iter_inc >= ITER_MAX)
                                hit_res = '{VERDICT_PASS, RSN_OPT_LIMIT};
                            else if (opt_byte == 8'd1)
                            begin
                                // A length of one makes the length byte the next kind,
                                // which reads as a NOP.
                                nxt_next  = len_sum + NEXT_W'(1);
                                iter_next = iter_inc2;
                                hit       = (iter_inc2 >= ITER_MAX);
                                hit_res   = '{VERDICT_PASS, RSN_OPT_LIMIT};
                            end
                            else
                                hit = 1'b0;
                        end
                    end
                    PH_MSS_SKIP:
                        phase_next = PH_MSS_HI;
                    PH_MSS_HI:
                    begin
                        mss_hi_next = opt_byte;
                        phase_next  = PH_MSS_LO;
                    end
                    PH_MSS_LO:
                    begin
                        hit        = 1'b1;
                        hit_res    = '{({cur_mss_hi, opt_byte} < mss_min_reg), RSN_MSS};
                        phase_next = PH_KIND;
                    end
                    default:
                        phase_next = PH_KIND;
                endcase

                if (!hit && last_byte)
                begin
                    hit     = 1'b1;
                    hit_res = '{VERDICT_PASS, RSN_STREAM};
                end
            end

            decided_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_min_reg    <= '0;
            pos_reg        <= '0;
            nxt_reg        <= '0;
            lim_reg        <= '0;
            iter_reg       <= '0;
            phase_reg      <= PH_KIND;
            mss_hi_reg     <= '0;
            decided_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_reg        <= '0;
            skid_reg       <= '0;
        end
        else
        begin
            if (wr_en)
                mss_min_reg <= wr_data;

            pos_reg     <= pos_next;
            nxt_reg     <= nxt_next;
            lim_reg     <= lim_next;
            iter_reg    <= iter_next;
            phase_reg   <= phase_next;
            mss_hi_reg  <= mss_hi_next;
            decided_reg <= decided_next;

            if (!out_valid_reg || !out_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= hit;
                    skid_reg       <= hit_res;
                end
                else
                begin
                    out_reg       <= hit_res;
                    out_valid_reg <= hit;
                end
            end
            else if (hit)
            begin
                skid_reg       <= hit_res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output is empty");

    a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict) |-> (reason == RSN_MSS || reason == RSN_BAD_LEN))
        else $error("drop issued with a reason that only passes");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !decided_reg |-> (iter_reg < ITER_MAX))
        else $error("open packet has used up its option iterations");

    a_hit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && skid_valid_reg) |-> (out_valid_reg && !out_stall))
        else $error("result produced with no room in the output stages");
`endif

endmodule
